// ===== hdl/rbhe_pkg.sv =====
// ----------------------------------------------------------------------------
// rbhe_pkg
// Shared types, codes and helpers for the record binary heap engine.
// ----------------------------------------------------------------------------
package rbhe_pkg;

  localparam int CAPACITY_DEF = 32;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  age;
    logic [7:0]  height;
    logic [9:0]  weight;
  } rec_t;

  localparam logic [2:0] MODE_LOAD     = 3'd0;
  localparam logic [2:0] MODE_BUILD    = 3'd1;
  localparam logic [2:0] MODE_INSERT   = 3'd2;
  localparam logic [2:0] MODE_DELETE   = 3'd3;
  localparam logic [2:0] MODE_YOUNGEST = 3'd4;
  localparam logic [2:0] MODE_READ     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_APPEND, S_BLD_INIT, S_BLD_NEXT,
    S_SD_RN, S_SD_RL, S_SD_RR, S_SD_CR, S_SD_CHK, S_SD_W2,
    S_SC_RD, S_SC_CMP, S_DEL_RD, S_DEL_WR, S_RD_RD, S_RD_CAP, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RA_NODE, RA_LEFT, RA_RIGHT, RA_SCAN, RA_LAST, RA_INDEX
  } raddr_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_APPEND, WR_NODE, WR_CHILD, WR_PICK
  } wr_sel_t;

  typedef struct packed {
    logic       latch;
    raddr_sel_t ra;
    wr_sel_t    wr;
    logic       cap_p;
    logic       cap_l;
    logic       cap_r;
    logic       bld_init;
    logic       bld_dec;
    logic       node_step;
    logic       scan_init;
    logic       scan_cap;
    logic       read_cap;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       st_we;
    logic [1:0] st_val;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       ridx_bad;
    logic       i_zero;
    logic       best_is_node;
    logic       scan_last;
    logic       out_busy;
  } sts_t;

  // true when a must sit above b
  function automatic logic ranks(rec_t a, rec_t b, logic by_age);
    if (by_age) begin
      return a.age < b.age;
    end
    return a.weight > b.weight;
  endfunction

endpackage

// ===== hdl/rbhe_ifs.sv =====
// ----------------------------------------------------------------------------
// rbhe_ifs
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rbhe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] rec_id;
  logic [7:0]  rec_age;
  logic [7:0]  rec_height;
  logic [9:0]  rec_weight;
  logic [4:0]  read_index;
  modport source (output valid, mode, rec_id, rec_age, rec_height, rec_weight,
                  read_index, input ready);
  modport sink (input valid, mode, rec_id, rec_age, rec_height, rec_weight,
                read_index, output ready);
endinterface

interface rbhe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_id;
  logic [7:0]  out_age;
  logic [7:0]  out_height;
  logic [9:0]  out_weight;
  logic [5:0]  out_count;
  modport source (output valid, status, out_id, out_age, out_height, out_weight,
                  out_count, input ready);
  modport sink (input valid, status, out_id, out_age, out_height, out_weight,
                out_count, output ready);
endinterface

// ===== hdl/record_binary_heap_engine_top.sv =====
// ----------------------------------------------------------------------------
// record_binary_heap_engine_top
// Record store kept as a binary heap (min on age or max on weight).
//
//   channel  dir  handshake     payload
//   cfg      in   cfg_we        cfg_data (order_by_age)
//   in_ch    in   valid/ready   mode, rec_*, read_index
//   out_ch   out  valid/ready   status, out_*, out_count
//
// One item at a time; each item yields one result item.
// Scans read and compare each record in turn.
// Build runs count/2 sift-downs over one RAM port; each level reads the node
// and both children, then writes node and child on a swap. Insert and delete add a build.
// Synchronous reset empties the store; no clearing pass.
// A stalled result holds in the output register; the engine waits in done.
// ----------------------------------------------------------------------------
module record_binary_heap_engine_top #(
  parameter int CAPACITY = rbhe_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_data,
  rbhe_in_if.sink    in_ch,
  rbhe_out_if.source out_ch
);
  import rbhe_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rec_t in_rec, out_rec;

  assign in_rec = '{id: in_ch.rec_id, age: in_ch.rec_age,
                    height: in_ch.rec_height, weight: in_ch.rec_weight};

  rbhe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbhe_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_mode    (in_ch.mode),
    .in_rec     (in_rec),
    .in_ridx    (in_ch.read_index),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_rec    (out_rec),
    .out_count  (out_ch.out_count)
  );

  assign out_ch.out_id     = out_rec.id;
  assign out_ch.out_age    = out_rec.age;
  assign out_ch.out_height = out_rec.height;
  assign out_ch.out_weight = out_rec.weight;

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_FULL |-> out_ch.out_count == 6'(CAPACITY))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status == ST_EMPTY |-> out_ch.out_count == 6'd0)
    else $error("empty status with records held");

  a_no_full_ok: assert property (@(posedge clk) disable iff (rst)
    sts.full |-> !sts.empty)
    else $error("store both full and empty");
endmodule

// ===== hdl/rbhe_ram.sv =====
// ----------------------------------------------------------------------------
// rbhe_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbhe_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/rbhe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbhe_ctrl
// Sequencer: dispatch, append, Floyd build with sift-down, scans, indexed reads and result hand-off.
// ----------------------------------------------------------------------------
module rbhe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rbhe_pkg::sts_t sts,
  output rbhe_pkg::cmd_t cmd
);
  import rbhe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.ra     = RA_NODE;
    cmd.wr     = WR_NONE;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_OK;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.mode)
          MODE_LOAD, MODE_INSERT: begin
            if (sts.full) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_FULL;
              state_next = S_DONE;
            end else begin
              state_next = S_APPEND;
            end
          end
          MODE_BUILD: state_next = S_BLD_INIT;
          MODE_DELETE, MODE_YOUNGEST: begin
            if (sts.empty) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_EMPTY;
              state_next = S_DONE;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SC_RD;
            end
          end
          MODE_READ: begin
            if (sts.ridx_bad) begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_INDEX;
              state_next = S_DONE;
            end else begin
              state_next = S_RD_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_APPEND: begin
        cmd.wr      = WR_APPEND;
        cmd.cnt_inc = 1'b1;
        state_next  = (sts.mode == MODE_INSERT) ? S_BLD_INIT : S_DONE;
      end
      S_BLD_INIT: begin
        cmd.bld_init = 1'b1;
        state_next   = S_BLD_NEXT;
      end
      S_BLD_NEXT: begin
        if (sts.i_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.bld_dec = 1'b1;
          state_next  = S_SD_RN;
        end
      end
      S_SD_RN: begin
        cmd.ra     = RA_NODE;
        state_next = S_SD_RL;
      end
      S_SD_RL: begin
        cmd.ra     = RA_LEFT;
        cmd.cap_p  = 1'b1;
        state_next = S_SD_RR;
      end
      S_SD_RR: begin
        cmd.ra     = RA_RIGHT;
        cmd.cap_l  = 1'b1;
        state_next = S_SD_CR;
      end
      S_SD_CR: begin
        cmd.cap_r  = 1'b1;
        state_next = S_SD_CHK;
      end
      S_SD_CHK: begin
        if (sts.best_is_node) begin
          state_next = S_BLD_NEXT;
        end else begin
          cmd.wr     = WR_NODE;
          state_next = S_SD_W2;
        end
      end
      S_SD_W2: begin
        cmd.wr        = WR_CHILD;
        cmd.node_step = 1'b1;
        state_next    = S_SD_RN;
      end
      S_SC_RD: begin
        cmd.ra     = RA_SCAN;
        state_next = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd.scan_cap = 1'b1;
        if (!sts.scan_last) begin
          state_next = S_SC_RD;
        end else if (sts.mode == MODE_DELETE) begin
          state_next = S_DEL_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DEL_RD: begin
        cmd.ra     = RA_LAST;
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.wr      = WR_PICK;
        cmd.cnt_dec = 1'b1;
        state_next  = S_BLD_INIT;
      end
      S_RD_RD: begin
        cmd.ra     = RA_INDEX;
        state_next = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.read_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/rbhe_dp.sv =====
// ----------------------------------------------------------------------------
// rbhe_dp
// Datapath: record RAM, count, heap indexes, compare registers, result register.
// ----------------------------------------------------------------------------
module rbhe_dp #(
  parameter int CAPACITY = rbhe_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_data,
  input  logic [2:0]     in_mode,
  input  rbhe_pkg::rec_t in_rec,
  input  logic [4:0]     in_ridx,
  input  rbhe_pkg::cmd_t cmd,
  output rbhe_pkg::sts_t sts,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [1:0]     out_status,
  output rbhe_pkg::rec_t out_rec,
  output logic [5:0]     out_count
);
  import rbhe_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = CW + 1;

  logic          order_by_age;
  logic [CW-1:0] count;
  logic [2:0]    mode;
  rec_t          nrec;
  logic [4:0]    ridx;
  logic [IW-1:0] node;
  logic [CW-1:0] iter;
  logic [IW-1:0] kidx;
  rec_t          prec;
  rec_t          best_rec;
  logic [IW-1:0] best_idx;
  rec_t          pick;
  logic [IW-1:0] pick_idx;
  logic [1:0]    status;

  logic [XW-1:0] lft, rgt;
  logic          l_ok, r_ok, take;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  rec_t          wdata, rdata;

  assign lft  = (XW'(node) << 1) + XW'(1);
  assign rgt  = lft + XW'(1);
  assign l_ok = lft < XW'(count);
  assign r_ok = rgt < XW'(count);
  assign take = (kidx == '0) ||
                ((mode == MODE_DELETE) ? (rdata.age > pick.age) : (rdata.age < pick.age));

  always_comb begin
    unique case (cmd.ra)
      RA_NODE:  raddr = node;
      RA_LEFT:  raddr = lft[IW-1:0];
      RA_RIGHT: raddr = rgt[IW-1:0];
      RA_SCAN:  raddr = kidx;
      RA_LAST:  raddr = IW'(count - CW'(1));
      RA_INDEX: raddr = IW'(ridx);
      default:  raddr = node;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = node;
    wdata = best_rec;
    unique case (cmd.wr)
      WR_APPEND: begin
        waddr = IW'(count);
        wdata = nrec;
      end
      WR_NODE: begin
        waddr = node;
        wdata = best_rec;
      end
      WR_CHILD: begin
        waddr = best_idx;
        wdata = prec;
      end
      WR_PICK: begin
        waddr = pick_idx;
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  rbhe_ram #(.WIDTH($bits(rec_t)), .DEPTH(CAPACITY), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      order_by_age <= 1'b0;
      count        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_by_age <= cfg_data;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode <= in_mode;
      nrec <= in_rec;
      ridx <= in_ridx;
      pick <= '0;
    end
    if (cmd.st_we) begin
      status <= cmd.st_val;
    end
    if (cmd.bld_init) begin
      iter <= count >> 1;
    end
    if (cmd.bld_dec) begin
      iter <= iter - CW'(1);
      node <= IW'(iter - CW'(1));
    end
    if (cmd.node_step) begin
      node <= best_idx;
    end
    if (cmd.cap_p) begin
      prec     <= rdata;
      best_rec <= rdata;
      best_idx <= node;
    end
    if ((cmd.cap_l && l_ok && ranks(rdata, best_rec, order_by_age)) ||
        (cmd.cap_r && r_ok && ranks(rdata, best_rec, order_by_age))) begin
      best_rec <= rdata;
      best_idx <= cmd.cap_l ? lft[IW-1:0] : rgt[IW-1:0];
    end
    if (cmd.scan_init) begin
      kidx <= '0;
    end
    if (cmd.scan_cap) begin
      kidx <= kidx + IW'(1);
      if (take) begin
        pick     <= rdata;
        pick_idx <= kidx;
      end
    end
    if (cmd.read_cap) begin
      pick <= rdata;
    end
    if (cmd.out_load) begin
      out_status <= status;
      out_rec    <= pick;
      out_count  <= 6'(count);
    end
  end

  always_comb begin
    sts.mode         = mode;
    sts.full         = (count == CW'(CAPACITY));
    sts.empty        = (count == '0);
    sts.ridx_bad     = (32'(ridx) >= 32'(count));
    sts.i_zero       = (iter == '0);
    sts.best_is_node = (best_idx == node);
    sts.scan_last    = ((XW'(kidx) + XW'(1)) >= XW'(count));
    sts.out_busy     = out_valid && !out_ready;
  end
endmodule
